// File: rtl/core/dual_wheel_velocity_pid_unit_defines.svh
// assertion macros for the wheel velocity controller
`ifndef DUAL_WHEEL_VELOCITY_PID_UNIT_DEFINES_SVH
`define DUAL_WHEEL_VELOCITY_PID_UNIT_DEFINES_SVH
`ifndef SYNTH
`define DWV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dwv assertion failed");
`define DWV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dwv assertion failed");
`else
`define DWV_ASSERT_NOW(lbl, ante, cons)
`define DWV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/dwv_pkg.sv
`timescale 1ns / 1ps
package dwv_pkg;
  localparam int SPEED_FRAC_BITS = 12;
  localparam int ONE = 1 << SPEED_FRAC_BITS;
  // 1.092/1536 m per count, ms folded into the divide
  localparam int SPD_K = 91 * ONE / 128 * 1000 / 1000;
  localparam int FILT_K = 3000;
  localparam int GAIN_SCALE = 1000;
  localparam longint BND_NUM = longint'(15360000) << SPEED_FRAC_BITS;
  localparam longint INT32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam int DEAD_LIM = (16 * ONE + 99) / 100;
  localparam int REV_LIM = -(ONE / 2);
  localparam int CMD_NEUTRAL = 64;
  localparam int CMD_LOW = 40;
  localparam int CMD_MAX = 63;
  localparam int NUM_REGS = 8;

  // final scaling: rounding shift by 2^(8+F), then divide by the gain scale
  localparam int U_SHIFT = 8 + SPEED_FRAC_BITS;
  localparam longint U_HALF = longint'(GAIN_SCALE / 2) << U_SHIFT;
  localparam int U_TMAX = CMD_MAX * GAIN_SCALE;
  // ceil(2^24 / 1000); matches the true divide only for values up to 21998, not up to U_TMAX
  localparam int U_RECIP = 16778;
  localparam int U_RECIP_SH = 24;

  // gain offsets inside one wheel's group of four registers
  localparam logic [1:0] G_PROP = 2'd0;
  localparam logic [1:0] G_INTEG = 2'd1;
  localparam logic [1:0] G_DERIV = 2'd2;
  localparam logic [1:0] G_FF = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_SPD_MUL, S_SPD_DIV, S_SPD_WAIT, S_DIF_MUL, S_FLT_MUL, S_FLT_ADD,
    S_FLT_DIV, S_FLT_WAIT, S_INT_MUL, S_INT_ADD, S_BND_DIV, S_BND_WAIT,
    S_P1, S_P2, S_D1, S_D2, S_K1, S_K2, S_I1, S_I2, S_U_DIV, S_U_WAIT, S_FIN
  } dwv_state_t;

  typedef enum logic [1:0] {DV_IDLE, DV_PREP, DV_RUN, DV_DONE} dwv_div_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7FFF;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > INT32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < -INT32_MAX - 64'sd1) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = 17'(v);
    return (w < 0) ? 17'(-w) : 17'(w);
  endfunction
endpackage

// File: rtl/core/dual_wheel_velocity_pid_unit.sv
`timescale 1ns / 1ps
`include "dual_wheel_velocity_pid_unit_defines.svh"
// Two-wheel velocity PID with feedforward, one request per control tick.
// Input channel: in_valid / in_stall with encoder counts, elapsed ms, targets
// and the stop input. A request is taken only while the unit is idle; in_stall
// is high from the cycle after a request until its result is registered.
// Each wheel runs through one shared 34x27 multiplier and one shared rounding
// divider that retires one quotient bit a cycle (64 quotient bits, after a prepare step). Per wheel
// there are two or three divides (the integral bound only for a nonzero
// integral gain) and twelve multiplies; the final scaling is a rounding shift
// and a reciprocal multiply.
// Result channel: out_valid / out_stall from a single output register. A new
// request may be taken while the previous result still waits; the unit holds
// the finished result in its last step until the output register is free.
// Configuration: cfg_valid / cfg_ready, always ready; index 0..7 selects the
// gain registers, other indexes are ignored. Write only while idle.
// Reset (rst_n low, synchronous) clears gains, integrals, filtered
// derivatives, previous speeds and the output valid.
module dual_wheel_velocity_pid_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_count_left,
  input  logic signed [15:0] in_count_right,
  input  logic [15:0]        in_elapsed_ms,
  input  logic signed [15:0] in_target_left,
  input  logic signed [15:0] in_target_right,
  input  logic               in_stop_pressed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_right_byte,
  output logic [7:0]         out_left_byte,
  output logic signed [15:0] out_speed_left,
  output logic signed [15:0] out_speed_right,
  output logic               out_motor_stop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import dwv_pkg::*;

  dwv_state_t state_r, state_nxt;
  logic w_r, w_nxt;

  logic signed [15:0] gain_r [NUM_REGS];
  logic signed [15:0] count_r [2], count_nxt [2];
  logic signed [15:0] target_r [2], target_nxt [2];
  logic [15:0]        ms_r, ms_nxt;
  logic               stop_r, stop_nxt;

  logic signed [31:0] integ_r [2], integ_nxt [2];
  logic signed [31:0] filt_r [2], filt_nxt [2];
  logic signed [15:0] prev_r [2], prev_nxt [2];

  logic signed [15:0] speed_r, speed_nxt;
  logic signed [16:0] err_r, err_nxt;
  logic signed [31:0] filt_new_r, filt_new_nxt;
  logic signed [31:0] integ_new_r, integ_new_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [60:0] prod_r, prod_nxt;
  logic [6:0]         cmd_r [2], cmd_nxt [2];
  logic signed [15:0] spd_r [2], spd_nxt [2];

  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         right_r, right_nxt;
  logic [7:0]         left_r, left_nxt;
  logic signed [15:0] sl_r, sl_nxt, sr_r, sr_nxt;
  logic               ms_out_r, ms_out_nxt;

  logic signed [33:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [60:0] mul_p;
  logic               mul_en;

  logic               div_start, div_round, div_done;
  logic signed [63:0] div_num, div_quot;
  logic [31:0]        div_den;

  logic signed [15:0] g_p, g_i, g_d, g_k;
  logic               fin_go, accept;
  logic signed [32:0] bnd;
  logic [6:0]         cmd_w;
  logic [6:0]         pl, pr;
  logic [63:0]        s_mag, s_rnd;
  logic [15:0]        t_sat;
  logic [6:0]         q_u;

  assign g_p = gain_r[{w_r, G_PROP}];
  assign g_i = gain_r[{w_r, G_INTEG}];
  assign g_d = gain_r[{w_r, G_DERIV}];
  assign g_k = gain_r[{w_r, G_FF}];
  assign accept = in_valid && !in_stall;
  assign fin_go = !out_valid_r || !out_stall;
  assign mul_p = mul_a * mul_b;
  assign cfg_ready = 1'b1;

  dwv_rdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .round_en (div_round),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SPD_MUL;
      S_SPD_MUL:  state_nxt = S_SPD_DIV;
      S_SPD_DIV:  state_nxt = S_SPD_WAIT;
      S_SPD_WAIT: if (div_done) state_nxt = S_DIF_MUL;
      S_DIF_MUL:  state_nxt = S_FLT_MUL;
      S_FLT_MUL:  state_nxt = S_FLT_ADD;
      S_FLT_ADD:  state_nxt = S_FLT_DIV;
      S_FLT_DIV:  state_nxt = S_FLT_WAIT;
      S_FLT_WAIT: if (div_done) state_nxt = S_INT_MUL;
      S_INT_MUL:  state_nxt = S_INT_ADD;
      S_INT_ADD:  state_nxt = S_BND_DIV;
      S_BND_DIV:  state_nxt = (g_i == 0) ? S_P1 : S_BND_WAIT;
      S_BND_WAIT: if (div_done) state_nxt = S_P1;
      S_P1:       state_nxt = S_P2;
      S_P2:       state_nxt = S_D1;
      S_D1:       state_nxt = S_D2;
      S_D2:       state_nxt = S_K1;
      S_K1:       state_nxt = S_K2;
      S_K2:       state_nxt = S_I1;
      S_I1:       state_nxt = S_I2;
      S_I2:       state_nxt = S_U_DIV;
      S_U_DIV:    state_nxt = S_U_WAIT;
      S_U_WAIT:   state_nxt = w_r ? S_FIN : S_SPD_MUL;
      S_FIN:      if (fin_go) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // rounded magnitude of the sum over 2^(8+F), capped where the command saturates
  always_comb begin
    s_mag = (acc_r < 0) ? 64'(-acc_r) : 64'(acc_r);
    s_rnd = (s_mag + 64'(U_HALF)) >> U_SHIFT;
    t_sat = (s_rnd >= 64'(U_TMAX)) ? 16'(U_TMAX) : s_rnd[15:0];
    q_u = prod_r[U_RECIP_SH +: 7];
  end

  // unit controls and operand selection
  always_comb begin
    in_stall = (state_r != S_IDLE);
    mul_en = 1'b1;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_round = 1'b1;
    div_num = '0;
    div_den = '0;
    case (state_r)
      S_SPD_MUL: begin
        mul_a = 34'(count_r[w_r]);
        mul_b = 27'(SPD_K);
      end
      S_DIF_MUL: begin
        mul_a = 34'(prev_r[w_r]) - 34'(speed_r);
        mul_b = 27'(FILT_K);
      end
      S_FLT_MUL: begin
        mul_a = 34'(filt_r[w_r]);
        mul_b = 27'($signed({1'b0, ms_r}));
      end
      S_INT_MUL: begin
        mul_a = 34'(err_r);
        mul_b = 27'($signed({1'b0, ms_r}));
      end
      S_P1: begin
        mul_a = 34'(g_p);
        mul_b = 27'(GAIN_SCALE);
      end
      S_P2: begin
        mul_a = 34'(err_r);
        mul_b = $signed(prod_r[26:0]);
      end
      S_D1: begin
        mul_a = 34'(g_d);
        mul_b = 27'(GAIN_SCALE);
      end
      S_D2: begin
        mul_a = 34'(filt_new_r);
        mul_b = $signed(prod_r[26:0]);
      end
      S_K1: begin
        mul_a = 34'(g_k);
        mul_b = 27'(GAIN_SCALE);
      end
      S_K2: begin
        mul_a = 34'(target_r[w_r]);
        mul_b = $signed(prod_r[26:0]);
      end
      S_I1: begin
        mul_a = 34'(integ_new_r);
        mul_b = 27'(g_i);
      end
      S_SPD_DIV: begin
        mul_en = 1'b0;
        div_start = 1'b1;
        div_num = 64'(prod_r);
        div_den = 32'(ms_r);
      end
      S_FLT_DIV: begin
        mul_en = 1'b0;
        div_start = 1'b1;
        div_num = acc_r;
        div_den = {14'd0, ms_r, 2'b00};
      end
      S_BND_DIV: begin
        mul_en = 1'b0;
        div_start = (g_i != 0);
        div_round = 1'b0;
        div_num = BND_NUM;
        div_den = 32'(abs17(g_i));
      end
      S_U_DIV: begin
        // divide by the gain scale as a reciprocal multiply
        mul_a = 34'(t_sat);
        mul_b = 27'(U_RECIP);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // command of the current wheel from the rounded sum, neutral inside the deadband
  always_comb begin
    if (acc_r < 0) cmd_w = 7'(CMD_NEUTRAL) + q_u;
    else cmd_w = 7'(CMD_NEUTRAL) - q_u;
    if (abs17(speed_r) < 17'(DEAD_LIM) && abs17(target_r[w_r]) < 17'(DEAD_LIM))
      cmd_w = 7'(CMD_NEUTRAL);
  end

  always_comb begin
    if (div_quot > INT32_MAX) bnd = 33'(INT32_MAX);
    else bnd = 33'(div_quot);
  end

  // overrides on both commands
  always_comb begin
    pl = cmd_r[0];
    pr = cmd_r[1];
    if (pl < 7'(CMD_LOW) && pr < 7'(CMD_LOW)) begin
      pl = 7'(CMD_NEUTRAL);
      pr = 7'(CMD_NEUTRAL);
    end
    if (spd_r[0] < 16'(REV_LIM) && spd_r[1] < 16'(REV_LIM)) begin
      pl = 7'(CMD_NEUTRAL);
      pr = 7'(CMD_NEUTRAL);
    end
  end

  // datapath
  always_comb begin
    w_nxt = w_r;
    count_nxt = count_r;
    target_nxt = target_r;
    ms_nxt = ms_r;
    stop_nxt = stop_r;
    integ_nxt = integ_r;
    filt_nxt = filt_r;
    prev_nxt = prev_r;
    speed_nxt = speed_r;
    err_nxt = err_r;
    filt_new_nxt = filt_new_r;
    integ_new_nxt = integ_new_r;
    acc_nxt = acc_r;
    prod_nxt = mul_en ? mul_p : prod_r;
    cmd_nxt = cmd_r;
    spd_nxt = spd_r;
    out_valid_nxt = out_valid_r && out_stall;
    right_nxt = right_r;
    left_nxt = left_r;
    sl_nxt = sl_r;
    sr_nxt = sr_r;
    ms_out_nxt = ms_out_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          w_nxt = 1'b0;
          count_nxt[0] = in_count_left;
          count_nxt[1] = in_count_right;
          target_nxt[0] = in_stop_pressed ? 16'sd0 : in_target_left;
          target_nxt[1] = in_stop_pressed ? 16'sd0 : in_target_right;
          ms_nxt = (in_elapsed_ms == 16'd0) ? 16'd1 : in_elapsed_ms;
          stop_nxt = in_stop_pressed;
          if (in_stop_pressed) begin
            integ_nxt[0] = '0;
            integ_nxt[1] = '0;
          end
        end
      end
      S_SPD_WAIT: if (div_done) speed_nxt = sat16(div_quot);
      S_DIF_MUL:  err_nxt = 17'(target_r[w_r]) - 17'(speed_r);
      S_FLT_MUL:  acc_nxt = 64'(prod_r);
      S_FLT_ADD:  acc_nxt = acc_r + 64'(prod_r);
      S_FLT_WAIT: if (div_done) filt_new_nxt = sat32(div_quot);
      S_INT_ADD:  integ_new_nxt = sat32(64'(integ_r[w_r]) + 64'(prod_r));
      S_BND_WAIT: begin
        if (div_done) begin
          if (33'(integ_new_r) > bnd) integ_new_nxt = bnd[31:0];
          else if (33'(integ_new_r) < -bnd) integ_new_nxt = 32'(-bnd);
        end
      end
      S_P1: acc_nxt = '0;
      S_D1, S_K1, S_I1, S_I2: acc_nxt = acc_r + 64'(prod_r);
      S_U_WAIT: begin
        cmd_nxt[w_r] = cmd_w;
        spd_nxt[w_r] = speed_r;
        filt_nxt[w_r] = filt_new_r;
        integ_nxt[w_r] = integ_new_r;
        prev_nxt[w_r] = speed_r;
        w_nxt = 1'b1;
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          right_nxt = pr;
          left_nxt = {1'b1, pl};
          sl_nxt = spd_r[0];
          sr_nxt = spd_r[1];
          ms_out_nxt = stop_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) gain_r[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        integ_r[i] <= '0;
        filt_r[i] <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready && cfg_index < 4'(NUM_REGS))
        gain_r[cfg_index[2:0]] <= $signed(cfg_data);
      integ_r <= integ_nxt;
      filt_r <= filt_nxt;
      prev_r <= prev_nxt;
    end
    w_r <= w_nxt;
    count_r <= count_nxt;
    target_r <= target_nxt;
    ms_r <= ms_nxt;
    stop_r <= stop_nxt;
    speed_r <= speed_nxt;
    err_r <= err_nxt;
    filt_new_r <= filt_new_nxt;
    integ_new_r <= integ_new_nxt;
    acc_r <= acc_nxt;
    prod_r <= prod_nxt;
    cmd_r <= cmd_nxt;
    spd_r <= spd_nxt;
    right_r <= right_nxt;
    left_r <= left_nxt;
    sl_r <= sl_nxt;
    sr_r <= sr_nxt;
    ms_out_r <= ms_out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_right_byte = right_r;
  assign out_left_byte = left_r;
  assign out_speed_left = sl_r;
  assign out_speed_right = sr_r;
  assign out_motor_stop = ms_out_r;

  `DWV_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  `DWV_ASSERT_NOW(a_done_when_waiting, div_done, state_r == S_SPD_WAIT ||
    state_r == S_FLT_WAIT || state_r == S_BND_WAIT || state_r == S_U_WAIT)
  `DWV_ASSERT_NOW(a_left_marker, out_valid, out_left_byte[7])
endmodule

// File: rtl/core/dwv_rdiv.sv
`timescale 1ns / 1ps
module dwv_rdiv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               round_en,
  input  logic signed [63:0] num,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [63:0] quot
);
  import dwv_pkg::*;

  dwv_div_state_t state_r, state_nxt;
  logic        neg_r, neg_nxt;
  logic        rnd_r, rnd_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] den_r, den_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] part;
  logic        fits;

  assign part = {rem_r, dvd_r[63]};
  assign fits = part >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: if (start) state_nxt = DV_PREP;
      DV_PREP: state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == 6'h3F) state_nxt = DV_DONE;
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == DV_DONE);
    quot = neg_r ? -$signed(dvd_r) : $signed(dvd_r);
  end

  always_comb begin
    neg_nxt = neg_r;
    rnd_nxt = rnd_r;
    dvd_nxt = dvd_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          neg_nxt = num < 0;
          dvd_nxt = (num < 0) ? 64'(-num) : 64'(num);
          den_nxt = den;
          rnd_nxt = round_en;
        end
      end
      DV_PREP: begin
        // bias by half the divisor for round to nearest, when rounding is enabled
        dvd_nxt = dvd_r + (rnd_r ? 64'(den_r >> 1) : 64'd0);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      DV_RUN: begin
        rem_nxt = fits ? 32'(part - {1'b0, den_r}) : part[31:0];
        dvd_nxt = {dvd_r[62:0], fits};
        cnt_nxt = cnt_r + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= DV_IDLE;
    else state_r <= state_nxt;
    neg_r <= neg_nxt;
    rnd_r <= rnd_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end
endmodule

// File: sim/dual_wheel_velocity_pid_unit_tb.sv
`timescale 1ns / 1ps
module dual_wheel_velocity_pid_unit_tb;

  localparam int FRAC = 12;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  // gain register indexes, and one index out of range
  localparam logic [3:0] REG_P_L = 4'd0;
  localparam logic [3:0] REG_I_L = 4'd1;
  localparam logic [3:0] REG_D_L = 4'd2;
  localparam logic [3:0] REG_K_L = 4'd3;
  localparam logic [3:0] REG_P_R = 4'd4;
  localparam logic [3:0] REG_I_R = 4'd5;
  localparam logic [3:0] REG_D_R = 4'd6;
  localparam logic [3:0] REG_K_R = 4'd7;
  localparam logic [3:0] REG_BAD = 4'd9;
  localparam int NUM_GAINS = 8;

  typedef struct {
    logic signed [15:0] cnt_l;
    logic signed [15:0] cnt_r;
    logic [15:0]        ms;
    logic signed [15:0] tgt_l;
    logic signed [15:0] tgt_r;
    logic               stop;
  } tick_t;

  typedef struct {
    logic [6:0]         rbyte;
    logic [7:0]         lbyte;
    logic signed [15:0] spd_l;
    logic signed [15:0] spd_r;
    logic               mstop;
  } cmd_t;

  class wheel_cmd_scoreboard;
    longint gain[NUM_GAINS];
    longint integ[2];
    longint filt[2];
    longint prev_spd[2];
    cmd_t   cmd_q[$];
    int     errors;
    int     n_in;

    function void clear();
      for (int i = 0; i < NUM_GAINS; i++) gain[i] = 0;
      for (int w = 0; w < 2; w++) begin
        integ[w] = 0;
        filt[w] = 0;
        prev_spd[w] = 0;
      end
      errors = 0;
      n_in = 0;
    endfunction

    function void set_gain(logic [3:0] idx, logic [15:0] data);
      if (idx < NUM_GAINS) gain[idx] = longint'($signed(data));
    endfunction

    // round to nearest, halves away from zero, den > 0
    function longint round_div(longint num, longint den);
      longint m;
      longint q;
      m = (num < 0) ? -num : num;
      q = (m + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint wheel_cmd(int w, longint cnt, longint ms, longint tgt, output longint spd);
      longint err, fnew, inew, bnd, s, u, pg, ig, dg, kg;
      pg = gain[4*w];
      ig = gain[4*w+1];
      dg = gain[4*w+2];
      kg = gain[4*w+3];
      spd = clip(round_div(cnt * 91 * ONE_Q, 128 * ms), -32768, 32767);
      err = tgt - spd;
      fnew = round_div(3000 * (prev_spd[w] - spd) + filt[w] * ms, 4 * ms);
      fnew = clip(fnew, I32_MIN, I32_MAX);
      inew = clip(integ[w] + err * ms, I32_MIN, I32_MAX);
      if (ig != 0) begin
        bnd = 15360000 * ONE_Q / ((ig < 0) ? -ig : ig);
        if (bnd > I32_MAX) bnd = I32_MAX;
        inew = clip(inew, -bnd, bnd);
      end
      s = 1000 * (pg * err + dg * fnew + kg * tgt) + ig * inew;
      u = round_div(s, 1000 * 256 * ONE_Q);
      u = clip(-u, -63, 63) + 64;
      // deadband: slow wheel with a slow target sits at neutral
      if (((spd < 0) ? -spd : spd) * 100 < 16 * ONE_Q &&
          ((tgt < 0) ? -tgt : tgt) * 100 < 16 * ONE_Q) u = 64;
      filt[w] = fnew;
      integ[w] = inew;
      prev_spd[w] = spd;
      return u;
    endfunction

    function void note_input(tick_t t);
      longint ms, tl, tr, sl, sr, pl, pr;
      cmd_t e;
      n_in++;
      ms = (t.ms == 0) ? 1 : longint'(t.ms);
      tl = t.tgt_l;
      tr = t.tgt_r;
      if (t.stop) begin
        tl = 0;
        tr = 0;
        integ[0] = 0;
        integ[1] = 0;
      end
      pl = wheel_cmd(0, longint'(t.cnt_l), ms, tl, sl);
      pr = wheel_cmd(1, longint'(t.cnt_r), ms, tr, sr);
      if (pl < 40 && pr < 40) begin
        pl = 64;
        pr = 64;
      end
      if (sl * 2 < -ONE_Q && sr * 2 < -ONE_Q) begin
        pl = 64;
        pr = 64;
      end
      e.rbyte = pr[6:0];
      e.lbyte = 8'(128 + pl);
      e.spd_l = sl[15:0];
      e.spd_r = sr[15:0];
      e.mstop = t.stop;
      cmd_q.push_back(e);
    endfunction

    function void check_result(cmd_t a);
      cmd_t e;
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected result rb=%0d lb=%0d", $time, a.rbyte, a.lbyte);
        errors++;
        return;
      end
      e = cmd_q.pop_front();
      if (a.rbyte !== e.rbyte) begin
        $display("%0t: right_byte exp %0d got %0d", $time, e.rbyte, a.rbyte);
        errors++;
      end
      if (a.lbyte !== e.lbyte) begin
        $display("%0t: left_byte exp %0d got %0d", $time, e.lbyte, a.lbyte);
        errors++;
      end
      if (a.spd_l !== e.spd_l) begin
        $display("%0t: speed_left exp %0d got %0d", $time, e.spd_l, a.spd_l);
        errors++;
      end
      if (a.spd_r !== e.spd_r) begin
        $display("%0t: speed_right exp %0d got %0d", $time, e.spd_r, a.spd_r);
        errors++;
      end
      if (a.mstop !== e.mstop) begin
        $display("%0t: motor_stop exp %0d got %0d", $time, e.mstop, a.mstop);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_count_left = '0;
  logic signed [15:0] in_count_right = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic signed [15:0] in_target_left = '0;
  logic signed [15:0] in_target_right = '0;
  logic in_stop_pressed = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] out_right_byte;
  logic [7:0] out_left_byte;
  logic signed [15:0] out_speed_left;
  logic signed [15:0] out_speed_right;
  logic out_motor_stop;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  wheel_cmd_scoreboard sb;
  bit quiet = 0;
  bit hold_done = 0;
  int hold_cnt = 0;

  dual_wheel_velocity_pid_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (in_valid && !in_stall)
        sb.note_input('{in_count_left, in_count_right, in_elapsed_ms,
                        in_target_left, in_target_right, in_stop_pressed});
      if (out_valid && !out_stall)
        sb.check_result('{out_right_byte, out_left_byte, out_speed_left,
                          out_speed_right, out_motor_stop});
    end
  end

  // receiver: random stalls, one long hold-off so the unit backs up
  always @(posedge clk) begin
    if (sb != null && sb.n_in == 300 && !hold_done) begin
      hold_done <= 1;
      hold_cnt <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 23);
    end
  end

  task automatic send_tick(tick_t t);
    if (!quiet && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_count_left <= t.cnt_l;
    in_count_right <= t.cnt_r;
    in_elapsed_ms <= t.ms;
    in_target_left <= t.tgt_l;
    in_target_right <= t.tgt_r;
    in_stop_pressed <= t.stop;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pause until every outstanding request has its result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.cmd_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_gain(logic [3:0] idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_gain(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d, logic [15:0] k,
                            logic [15:0] p2, logic [15:0] i2, logic [15:0] d2,
                            logic [15:0] k2);
    write_gain(REG_P_L, p);
    write_gain(REG_I_L, i);
    write_gain(REG_D_L, d);
    write_gain(REG_K_L, k);
    write_gain(REG_P_R, p2);
    write_gain(REG_I_R, i2);
    write_gain(REG_D_R, d2);
    write_gain(REG_K_R, k2);
  endtask

  function automatic logic [15:0] rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom());
    if (r < 20) return 16'd0;
    return 16'($signed($urandom_range(0, 16384)) - 8192);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int ms;
    if ($urandom_range(0, 99) < 10) begin
      t = '{16'($urandom()), 16'($urandom()), 16'($urandom()),
            16'($urandom()), 16'($urandom()), 1'($urandom())};
      return t;
    end
    ms = ($urandom_range(0, 49) == 0) ? 0 : $urandom_range(1, 60);
    t.ms = 16'(ms);
    t.cnt_l = 16'($signed($urandom_range(0, 8 * ms + 8)) - (4 * ms + 4));
    t.cnt_r = 16'($signed($urandom_range(0, 8 * ms + 8)) - (4 * ms + 4));
    t.tgt_l = 16'($signed($urandom_range(0, 24576)) - 12288);
    t.tgt_r = 16'($signed($urandom_range(0, 24576)) - 12288);
    t.stop = ($urandom_range(0, 99) < 8);
    return t;
  endfunction

  initial begin
    tick_t t;
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_gains(16'd2560, 16'd512, 16'd64, 16'd256, 16'd2560, 16'd512, 16'd64, 16'd256);
    write_gain(REG_BAD, 16'h7FFF);
    // directed ticks
    send_tick('{16'sd0, 16'sd0, 16'd10, 16'sd0, 16'sd0, 1'b0});
    send_tick('{16'sd10, 16'sd10, 16'd0, 16'sd4096, 16'sd4096, 1'b0});
    send_tick('{16'sh7FFF, 16'sh8000, 16'd1, 16'sh7FFF, 16'sh8000, 1'b0});
    send_tick('{16'sh8000, 16'sh7FFF, 16'd65535, 16'sh8000, 16'sh7FFF, 1'b0});
    send_tick('{16'sd30, -16'sd30, 16'hFFFF, 16'sd8192, -16'sd8192, 1'b1});
    send_tick('{16'sd3, -16'sd3, 16'd20, 16'sd400, -16'sd400, 1'b0});
    send_tick('{-16'sd40, -16'sd40, 16'd10, -16'sd8192, -16'sd8192, 1'b0});
    send_tick('{16'sd40, 16'sd40, 16'd10, 16'sd12288, 16'sd12288, 1'b0});
    send_tick('{16'sd40, 16'sd40, 16'd10, 16'sd12288, 16'sd12288, 1'b1});
    send_tick('{16'sd1, 16'sd1, 16'd20, 16'sd0, 16'sd0, 1'b0});
    send_tick('{-16'sd25, 16'sd25, 16'd10, 16'sd0, 16'sd0, 1'b0});
    send_tick('{16'sd0, 16'sd0, 16'd10, -16'sd30000, 16'sd30000, 1'b0});
    send_tick('{16'sh5555, 16'shAAAA, 16'hAAAA, 16'sh5555, 16'shAAAA, 1'b0});
    drain();
    // extreme gains
    load_gains(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_tick('{16'sd20, -16'sd20, 16'd10, 16'sd4096, -16'sd4096, 1'b0});
    send_tick('{16'sh7FFF, 16'sh8000, 16'd0, 16'sh7FFF, 16'sh8000, 1'b0});
    send_tick('{-16'sd5, 16'sd5, 16'd3, 16'sd0, 16'sd0, 1'b1});
    send_tick('{16'sd0, 16'sd0, 16'd65535, -16'sd100, 16'sd100, 1'b0});
    send_tick('{16'sd10, 16'sd10, 16'd1, -16'sd4096, -16'sd4096, 1'b0});
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 1)
        load_gains(16'd4096, 16'd0, 16'd0, 16'd512, 16'd4096, 16'd0, 16'd0, 16'd512);
      else if (ph == 2)
        load_gains(16'd3000, -16'sd700, 16'd100, 16'd0, -16'sd3000, 16'd700, 16'd0, 16'd0);
      else
        load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                   rand_gain(), rand_gain(), rand_gain(), rand_gain());
      if (ph == 3) write_gain(4'd15, 16'h1234);
      for (int n = 0; n < 106; n++) begin
        quiet = (ph == 4 && n >= 20 && n < 90);
        t = rand_tick();
        send_tick(t);
      end
      quiet = 0;
      drain();
    end

    repeat (700) @(posedge clk);
    if (sb.errors == 0 && sb.cmd_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dwv_pkg.sv
rtl/core/dwv_rdiv.sv
rtl/core/dual_wheel_velocity_pid_unit.sv
sim/dual_wheel_velocity_pid_unit_tb.sv
